>>> rtl/vgas_pkg.sv
// Shared types, codes and defaults for the voxel grid A* search block.
package vgas_pkg;

  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;
  localparam int GRID_Z_DEF = 16;

  localparam int FLD_W     = 4;   // coordinate field width on the ports
  localparam int LEN_W     = 13;  // path length field width
  localparam int STEP_UNIT = 16;  // one step, 4 fraction bits

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [FLD_W-1:0] voxel_x;
    logic [FLD_W-1:0] voxel_y;
    logic [FLD_W-1:0] voxel_z;
    logic             solid;
    logic [FLD_W-1:0] start_x;
    logic [FLD_W-1:0] start_y;
    logic [FLD_W-1:0] start_z;
    logic [FLD_W-1:0] goal_x;
    logic [FLD_W-1:0] goal_y;
    logic [FLD_W-1:0] goal_z;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    logic [FLD_W-1:0] node_x;
    logic [FLD_W-1:0] node_y;
    logic [FLD_W-1:0] node_z;
    logic             last_node;
    logic             read_valid;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_INIT,
    S_SCAN,
    S_SCAN_TAIL,
    S_PICK,
    S_NB,
    S_OCC_UP,
    S_OCC_DN,
    S_OCC_CHK,
    S_NODE_CHK,
    S_SQRT,
    S_NEXT,
    S_FOUND,
    S_TC_CHK,
    S_TC_RD,
    S_TW_STEP,
    S_TW_RD,
    S_RD_WAIT,
    S_EMIT,
    S_WIPE
  } state_t;

endpackage

>>> rtl/vgas_ram.sv
// Generic single port RAM with registered read data.
module vgas_ram #(
  parameter int W = 1,
  parameter int D = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/vgas_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module vgas_isqrt #(
  parameter int IN_W = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IN_W-1:0]     value,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW    = OUT_W + 3;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [RW-1:0]    rem;
  logic [IN_W-1:0]  src;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW-1:0]    rem_t;
  logic [RW-1:0]    trial;
  logic             take;

  assign rem_t = {rem[RW-3:0], src[IN_W-1:IN_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        root <= '0;
        src  <= value;
        cnt  <= CNT_W'(OUT_W);
      end else if (busy) begin
        rem  <= take ? rem_t - trial : rem_t;
        root <= {root[OUT_W-2:0], take};
        src  <= {src[IN_W-3:0], 2'b00};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/voxel_grid_astar_search.sv
// Top level of the voxel grid A* search: sequencer around the map, node and path RAMs.
//
// Use: one request channel (in_valid / in_stall / in_req) and one result
// channel (out_valid / out_stall / out_res).
//  - Load requests write one occupancy bit if the voxel is in the grid; no result.
//  - Search requests give one result (found, path_length). A search first
//    sweeps the node RAM clear, one cell a cycle, then loops: a full scan
//    of the node RAM for the lowest open f, then 27 neighbour checks, each
//    with three map reads for one in the grid and a node read too for a
//    walkable one, plus a square root (one root bit per cycle) for every
//    walkable neighbour that is not closed.
//  - Read requests return the next path node.
// The block takes one request at a time; in_stall is low only when idle.
// A finished result sits in the output register until taken; while a
// stalled receiver holds it there, the next result waits in the block,
// which then stays busy, while loads are still taken once it is idle.
// Reset empties the path (path count and read pointer zero) and starts a
// clearing pass over the map, one cell a cycle, with in_stall high until
// it ends; the node and path RAMs need no clearing pass at reset.
module voxel_grid_astar_search #(
  parameter int GRID_X = vgas_pkg::GRID_X_DEF,
  parameter int GRID_Y = vgas_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vgas_pkg::GRID_Z_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  vgas_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output vgas_pkg::res_t out_res
);

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int YZ    = GRID_Y * GRID_Z;
  localparam int GM1   = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GM2   = (GM1 > GRID_Z) ? GM1 : GRID_Z;
  localparam int GMAX  = (GM2 > 16) ? GM2 : 16;
  localparam int CW    = $clog2(GMAX);
  localparam int SW    = CW + 2;
  localparam int SQ_W  = 2 * CW + 10;
  localparam int FA    = IDX_W + 5;
  localparam int FB    = CW + 6;
  localparam int F_W   = (FA > FB) ? FA : FB;
  localparam int D2_W  = 2 * CW + 2;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } crd_t;

  typedef struct packed {
    logic           open_f;
    logic           closed_f;
    logic [F_W-1:0] g;
    logic [F_W-1:0] f;
    crd_t           parent;
  } node_t;

  localparam int NODE_W = $bits(node_t);
  localparam int CRD_W  = $bits(crd_t);

  function automatic logic [IDX_W-1:0] idx_of(crd_t c);
    idx_of = IDX_W'(c.x) * IDX_W'(YZ) + IDX_W'(c.y) * IDX_W'(GRID_Z) + IDX_W'(c.z);
  endfunction

  vgas_pkg::state_t state, state_next;

  // request registers
  crd_t st, gl;
  logic st_ok;

  // scan
  logic [IDX_W-1:0] scan_idx;
  crd_t             scan_c;
  logic             d1_vld;
  crd_t             d1_c;
  logic             have;
  crd_t             best_c;
  node_t            best_w;

  // expansion
  crd_t           cur_c;
  logic [F_W-1:0] cur_g;
  logic [1:0]     ox, oy, oz;
  crd_t           nb_c;
  logic           s_n, s_up, up_ok, dn_ok;
  node_t          nd_w;
  logic [F_W-1:0] new_g;

  // trace and read-out
  crd_t             tr_c;
  logic [CNT_W-1:0] tr_n, tr_k;
  logic [CNT_W-1:0] path_count, rp;
  vgas_pkg::res_t   res;

  // RAM ports
  logic             occ_we, occ_wd, occ_rd;
  logic [IDX_W-1:0] occ_addr;
  logic             node_we;
  logic [IDX_W-1:0] node_addr;
  node_t            node_wd, node_rd;
  logic             path_we;
  logic [IDX_W-1:0] path_addr;
  crd_t             path_wd, path_rd;

  // square root
  logic            sq_start, sq_done;
  logic [SQ_W-1:0] sq_in;
  logic [SQ_W/2-1:0] sq_root;

  // combinational helpers
  logic           acc;
  crd_t           vox_c;
  logic           vox_ok;
  logic [SW-1:0]  nbx, nby, nbz;
  logic           nb_in;
  crd_t           nb_comb;
  logic [CW:0]    up_y;
  logic           up_ok_c, dn_ok_c;
  crd_t           up_c, dn_c;
  logic           walk;
  logic           upd;
  logic [F_W-1:0] f_new;
  logic           do_wr;
  logic           scan_end;
  logic           nb_end;
  logic           load_out;
  logic [CW-1:0]  adx, ady, adz;
  logic [2*CW+1:0] d2;

  assign in_stall = (state != vgas_pkg::S_IDLE);
  assign acc      = in_valid && !in_stall;

  assign vox_c  = '{x: CW'(in_req.voxel_x), y: CW'(in_req.voxel_y), z: CW'(in_req.voxel_z)};
  assign vox_ok = (CW'(in_req.voxel_x) < CW'(GRID_X - 1) || CW'(in_req.voxel_x) == CW'(GRID_X - 1))
               && (CW'(in_req.voxel_y) < CW'(GRID_Y - 1) || CW'(in_req.voxel_y) == CW'(GRID_Y - 1))
               && (CW'(in_req.voxel_z) < CW'(GRID_Z - 1) || CW'(in_req.voxel_z) == CW'(GRID_Z - 1));

  // neighbour of the current cell for offset (ox-1, oy-1, oz-1); -1 wraps high
  assign nbx     = SW'(cur_c.x) + SW'(ox) - SW'(1);
  assign nby     = SW'(cur_c.y) + SW'(oy) - SW'(1);
  assign nbz     = SW'(cur_c.z) + SW'(oz) - SW'(1);
  assign nb_in   = (nbx < SW'(GRID_X)) && (nby < SW'(GRID_Y)) && (nbz < SW'(GRID_Z));
  assign nb_comb = '{x: nbx[CW-1:0], y: nby[CW-1:0], z: nbz[CW-1:0]};

  assign up_y    = {1'b0, nb_c.y} + (CW+1)'(1);
  assign up_ok_c = up_y < (CW+1)'(GRID_Y);
  assign dn_ok_c = nb_c.y >= CW'(2);
  assign up_c    = '{x: nb_c.x, y: up_y[CW-1:0], z: nb_c.z};
  assign dn_c    = '{x: nb_c.x, y: nb_c.y - CW'(2), z: nb_c.z};
  assign walk    = !s_n && !s_up && occ_rd && dn_ok;

  assign upd = d1_vld && node_rd.open_f && (!have || node_rd.f < best_w.f);

  assign f_new = new_g + F_W'(sq_root);
  assign do_wr = sq_done && (!nd_w.open_f || f_new < nd_w.f);

  assign scan_end = (scan_idx == IDX_W'(CELLS - 1));
  assign nb_end   = (ox == 2'd2) && (oy == 2'd2) && (oz == 2'd2);
  assign load_out = (state == vgas_pkg::S_EMIT) && (!out_valid || !out_stall);

  // heuristic input: squared distance to the goal, scaled by 256
  assign adx   = (nb_c.x >= gl.x) ? nb_c.x - gl.x : gl.x - nb_c.x;
  assign ady   = (nb_c.y >= gl.y) ? nb_c.y - gl.y : gl.y - nb_c.y;
  assign adz   = (nb_c.z >= gl.z) ? nb_c.z - gl.z : gl.z - nb_c.z;
  assign d2    = D2_W'(adx) * D2_W'(adx) + D2_W'(ady) * D2_W'(ady)
               + D2_W'(adz) * D2_W'(adz);
  assign sq_in = {d2, 8'h00};
  assign sq_start = (state == vgas_pkg::S_NODE_CHK) && !node_rd.closed_f;

  vgas_ram #(.W(1), .D(CELLS)) u_occ (
    .clk(clk), .we(occ_we), .addr(occ_addr), .wdata(occ_wd), .rdata(occ_rd)
  );

  vgas_ram #(.W(NODE_W), .D(CELLS)) u_node (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(node_wd), .rdata(node_rd)
  );

  vgas_ram #(.W(CRD_W), .D(CELLS)) u_path (
    .clk(clk), .we(path_we), .addr(path_addr), .wdata(path_wd), .rdata(path_rd)
  );

  vgas_isqrt #(.IN_W(SQ_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_in), .done(sq_done), .root(sq_root)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vgas_pkg::S_WIPE:      if (scan_end) state_next = vgas_pkg::S_IDLE;
      vgas_pkg::S_IDLE: begin
        if (acc) begin
          case (in_req.kind)
            vgas_pkg::KIND_SEARCH: state_next = vgas_pkg::S_CLR;
            vgas_pkg::KIND_READ:
              state_next = (rp < path_count) ? vgas_pkg::S_RD_WAIT : vgas_pkg::S_EMIT;
            default: state_next = vgas_pkg::S_IDLE;
          endcase
        end
      end
      vgas_pkg::S_CLR: begin
        if (scan_end) begin
          state_next = st_ok ? vgas_pkg::S_INIT : vgas_pkg::S_EMIT;
        end
      end
      vgas_pkg::S_INIT:      state_next = vgas_pkg::S_SCAN;
      vgas_pkg::S_SCAN:      if (scan_end) state_next = vgas_pkg::S_SCAN_TAIL;
      vgas_pkg::S_SCAN_TAIL: state_next = vgas_pkg::S_PICK;
      vgas_pkg::S_PICK:      state_next = have ? vgas_pkg::S_NB : vgas_pkg::S_EMIT;
      vgas_pkg::S_NB:        state_next = nb_in ? vgas_pkg::S_OCC_UP : vgas_pkg::S_NEXT;
      vgas_pkg::S_OCC_UP:    state_next = vgas_pkg::S_OCC_DN;
      vgas_pkg::S_OCC_DN:    state_next = vgas_pkg::S_OCC_CHK;
      vgas_pkg::S_OCC_CHK: begin
        if (!walk) begin
          state_next = vgas_pkg::S_NEXT;
        end else if (nb_c == gl) begin
          state_next = vgas_pkg::S_FOUND;
        end else begin
          state_next = vgas_pkg::S_NODE_CHK;
        end
      end
      vgas_pkg::S_NODE_CHK:
        state_next = node_rd.closed_f ? vgas_pkg::S_NEXT : vgas_pkg::S_SQRT;
      vgas_pkg::S_SQRT:  if (sq_done) state_next = vgas_pkg::S_NEXT;
      vgas_pkg::S_NEXT:  state_next = nb_end ? vgas_pkg::S_SCAN : vgas_pkg::S_NB;
      vgas_pkg::S_FOUND: state_next = vgas_pkg::S_TC_CHK;
      vgas_pkg::S_TC_CHK: begin
        if (tr_c == st || tr_n >= CNT_W'(CELLS)) begin
          state_next = vgas_pkg::S_TW_STEP;
        end else begin
          state_next = vgas_pkg::S_TC_RD;
        end
      end
      vgas_pkg::S_TC_RD:   state_next = vgas_pkg::S_TC_CHK;
      vgas_pkg::S_TW_STEP:
        state_next = (tr_k == path_count) ? vgas_pkg::S_EMIT : vgas_pkg::S_TW_RD;
      vgas_pkg::S_TW_RD:   state_next = vgas_pkg::S_TW_STEP;
      vgas_pkg::S_RD_WAIT: state_next = vgas_pkg::S_EMIT;
      vgas_pkg::S_EMIT:    if (load_out) state_next = vgas_pkg::S_IDLE;
      default:             state_next = vgas_pkg::S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    occ_we    = 1'b0;
    occ_wd    = in_req.solid;
    occ_addr  = idx_of(nb_comb);
    node_we   = 1'b0;
    node_addr = idx_of(nb_c);
    node_wd   = '0;
    path_we   = 1'b0;
    path_addr = rp[IDX_W-1:0];
    path_wd   = tr_c;
    case (state)
      vgas_pkg::S_WIPE: begin
        occ_addr = scan_idx;
        occ_we   = 1'b1;
        occ_wd   = 1'b0;
      end
      vgas_pkg::S_IDLE: begin
        occ_addr = idx_of(vox_c);
        occ_we   = acc && (in_req.kind == vgas_pkg::KIND_LOAD) && vox_ok;
      end
      vgas_pkg::S_CLR: begin
        node_addr = scan_idx;
        node_we   = 1'b1;
      end
      vgas_pkg::S_INIT: begin
        node_addr = idx_of(st);
        node_we   = 1'b1;
        node_wd   = '{open_f: 1'b1, closed_f: 1'b0, g: '0, f: '0, parent: st};
      end
      vgas_pkg::S_SCAN: node_addr = scan_idx;
      vgas_pkg::S_PICK: begin
        node_addr = idx_of(best_c);
        node_we   = have;
        node_wd   = best_w;
        node_wd.open_f   = 1'b0;
        node_wd.closed_f = 1'b1;
      end
      vgas_pkg::S_OCC_UP: occ_addr = idx_of(up_c);
      vgas_pkg::S_OCC_DN: occ_addr = idx_of(dn_c);
      vgas_pkg::S_SQRT: begin
        node_we = do_wr;
        node_wd = '{open_f: 1'b1, closed_f: 1'b0, g: new_g, f: f_new, parent: cur_c};
      end
      vgas_pkg::S_FOUND: begin
        node_we = (nb_c != st);
        node_wd = '{open_f: 1'b0, closed_f: 1'b0, g: '0, f: '0, parent: cur_c};
      end
      vgas_pkg::S_TC_CHK:  node_addr = idx_of(tr_c);
      vgas_pkg::S_TW_STEP: begin
        node_addr = idx_of(tr_c);
        path_addr = IDX_W'(path_count - tr_k - CNT_W'(1));
        path_we   = (tr_k != path_count);
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vgas_pkg::S_WIPE;
      scan_idx   <= '0;
      path_count <= '0;
      rp         <= '0;
      d1_vld     <= 1'b0;
      have       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      d1_vld <= (state == vgas_pkg::S_SCAN);

      if (load_out) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // running minimum over the scan; strict compare keeps the lowest index
      if (upd) begin
        have   <= 1'b1;
        best_c <= d1_c;
        best_w <= node_rd;
      end

      case (state)
        vgas_pkg::S_WIPE: scan_idx <= scan_idx + IDX_W'(1);
        vgas_pkg::S_IDLE: begin
          res <= '0;
          if (acc && in_req.kind == vgas_pkg::KIND_SEARCH) begin
            st    <= '{x: CW'(in_req.start_x), y: CW'(in_req.start_y), z: CW'(in_req.start_z)};
            gl    <= '{x: CW'(in_req.goal_x), y: CW'(in_req.goal_y), z: CW'(in_req.goal_z)};
            st_ok <= (CW'(in_req.start_x) <= CW'(GRID_X - 1))
                  && (CW'(in_req.start_y) <= CW'(GRID_Y - 1))
                  && (CW'(in_req.start_z) <= CW'(GRID_Z - 1));
            rp         <= '0;
            path_count <= '0;
            scan_idx   <= '0;
          end
        end
        vgas_pkg::S_CLR: scan_idx <= scan_idx + IDX_W'(1);
        vgas_pkg::S_INIT: begin
          scan_idx <= '0;
          scan_c   <= '0;
          have     <= 1'b0;
        end
        vgas_pkg::S_SCAN: begin
          d1_c     <= scan_c;
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_c.z == CW'(GRID_Z - 1)) begin
            scan_c.z <= '0;
            if (scan_c.y == CW'(GRID_Y - 1)) begin
              scan_c.y <= '0;
              scan_c.x <= scan_c.x + CW'(1);
            end else begin
              scan_c.y <= scan_c.y + CW'(1);
            end
          end else begin
            scan_c.z <= scan_c.z + CW'(1);
          end
        end
        vgas_pkg::S_PICK: begin
          cur_c <= best_c;
          cur_g <= best_w.g;
          ox    <= '0;
          oy    <= '0;
          oz    <= '0;
        end
        vgas_pkg::S_NB: nb_c <= nb_comb;
        vgas_pkg::S_OCC_UP: begin
          s_n   <= occ_rd;
          up_ok <= up_ok_c;
        end
        vgas_pkg::S_OCC_DN: begin
          s_up  <= occ_rd && up_ok;
          dn_ok <= dn_ok_c;
        end
        vgas_pkg::S_NODE_CHK: begin
          nd_w  <= node_rd;
          new_g <= cur_g + F_W'(vgas_pkg::STEP_UNIT);
        end
        vgas_pkg::S_NEXT: begin
          if (nb_end) begin
            scan_idx <= '0;
            scan_c   <= '0;
            have     <= 1'b0;
          end else if (oz == 2'd2) begin
            oz <= '0;
            if (oy == 2'd2) begin
              oy <= '0;
              ox <= ox + 2'd1;
            end else begin
              oy <= oy + 2'd1;
            end
          end else begin
            oz <= oz + 2'd1;
          end
        end
        vgas_pkg::S_FOUND: begin
          tr_c <= nb_c;
          tr_n <= CNT_W'(1);
        end
        vgas_pkg::S_TC_CHK: begin
          if (tr_c == st || tr_n >= CNT_W'(CELLS)) begin
            path_count <= tr_n;
            tr_c       <= gl;
            tr_k       <= '0;
          end
        end
        vgas_pkg::S_TC_RD: begin
          tr_c <= node_rd.parent;
          tr_n <= tr_n + CNT_W'(1);
        end
        vgas_pkg::S_TW_STEP: begin
          if (tr_k == path_count) begin
            res.found       <= 1'b1;
            res.path_length <= vgas_pkg::LEN_W'(path_count);
          end
        end
        vgas_pkg::S_TW_RD: begin
          tr_c <= node_rd.parent;
          tr_k <= tr_k + CNT_W'(1);
        end
        vgas_pkg::S_RD_WAIT: begin
          res.node_x     <= path_rd.x[vgas_pkg::FLD_W-1:0];
          res.node_y     <= path_rd.y[vgas_pkg::FLD_W-1:0];
          res.node_z     <= path_rd.z[vgas_pkg::FLD_W-1:0];
          res.last_node  <= (rp + CNT_W'(1) == path_count);
          res.read_valid <= 1'b1;
          rp             <= rp + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/vgas_checker.sv
// Port level checks for the voxel grid A* search, bound to the top level.
module vgas_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input vgas_pkg::req_t in_req,
  input logic           out_valid,
  input logic           out_stall,
  input vgas_pkg::res_t out_res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_req.kind == vgas_pkg::KIND_SEARCH |=> in_stall)
    else $error("search request did not occupy the block");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_req.kind == vgas_pkg::KIND_LOAD |=> !in_stall)
    else $error("load request blocked the next request");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind voxel_grid_astar_search vgas_checker u_vgas_checker (.*);
